@@ rtl/desa_pkg.sv @@
// Package: operation and status codes and inter-module structs for the stack allocator.
`timescale 1ns / 1ps
`default_nettype none
package desa_pkg;

   typedef enum logic [1:0] {
      OP_ALLOC    = 2'd0,
      OP_MARK     = 2'd1,
      OP_REWIND   = 2'd2,
      OP_DROPMARK = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK     = 3'd0,
      ST_OOM    = 3'd1,
      ST_REWIND = 3'd2,
      ST_DROP   = 3'd3,
      ST_FULL   = 3'd4
   } status_type;

   localparam int ADDR_W = 16;

   // Command from the request datapath to one side's mark stack.
   typedef struct packed {
      logic              push;
      logic              pop;
      logic [ADDR_W-1:0] data;
   } stk_cmd_type;

   // Status of one side's mark stack.
   typedef struct packed {
      logic              full;
      logic              base_only;
      logic [ADDR_W-1:0] top_mark;
   } stk_stat_type;

endpackage
`default_nettype wire

@@ rtl/desa_if.sv @@
// Valid/ready channel interfaces for allocator requests and responses.
`timescale 1ns / 1ps
`default_nettype none
interface desa_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic        direction;
   logic [15:0] alloc_bytes;

   modport source (output valid, output req_type, output direction, output alloc_bytes,
                   input ready);
   modport sink   (input valid, input req_type, input direction, input alloc_bytes,
                   output ready);
endinterface

interface desa_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] address;
   logic [2:0]  status;
   logic [15:0] free_bytes;

   modport source (output valid, output address, output status, output free_bytes,
                   input ready);
   modport sink   (input valid, input address, input status, input free_bytes,
                   output ready);
endinterface
`default_nettype wire

@@ rtl/desa_mark_stack.sv @@
// One side's mark stack: cached top and second entries over a mark memory.
`timescale 1ns / 1ps
`default_nettype none
module desa_mark_stack
   import desa_pkg::*;
#(
   parameter int          MARK_DEPTH = 64,
   parameter logic [15:0] BASE_MARK  = 16'd0
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire stk_cmd_type cmd,
   output stk_stat_type     stat
);

   localparam int CW = $clog2(MARK_DEPTH + 1);
   localparam int IW = $clog2(MARK_DEPTH);

   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [ADDR_W-1:0] top_ff, top_in;
   logic [ADDR_W-1:0] second_ff;
   logic [ADDR_W-1:0] mem [MARK_DEPTH];

   logic          rd_base;
   logic [IW-1:0] rd_idx;
   logic [IW-1:0] wr_idx;

   // after a pop the new second entry is marks[cnt-3]; entry zero is the base mark
   assign rd_base = (cnt_ff <= CW'(3));
   assign rd_idx  = IW'(cnt_ff - CW'(3));
   assign wr_idx  = cnt_ff[IW-1:0];

   always_comb begin
      cnt_in = cnt_ff;
      top_in = top_ff;
      if (cmd.push) begin
         cnt_in = cnt_ff + CW'(1);
         top_in = cmd.data;
      end else if (cmd.pop) begin
         cnt_in = cnt_ff - CW'(1);
         top_in = second_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= CW'(1);
         top_ff <= BASE_MARK;
      end else begin
         cnt_ff <= cnt_in;
         top_ff <= top_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[wr_idx] <= cmd.data;
         second_ff   <= top_ff;
      end else if (cmd.pop) begin
         second_ff <= rd_base ? BASE_MARK : mem[rd_idx];
      end
   end

   assign stat.full      = (cnt_ff == CW'(MARK_DEPTH));
   assign stat.base_only = (cnt_ff <= CW'(1));
   assign stat.top_mark  = top_ff;

endmodule
`default_nettype wire

@@ rtl/double_ended_stack_allocator_top.sv @@
// Top level: double-ended stack allocator with per-side mark stacks.
// Response: an accepted request is held in the input register, then its result in the result register.
// Throughput: one request per cycle unless the response side stalls; the top update and mark push/pop never stall it.
// Reset: synchronous; tops return to their init values and each side keeps only its base mark.
// Mark memories need no clearing: entry zero is a constant and others are written before use.
`timescale 1ns / 1ps
`default_nettype none
module double_ended_stack_allocator_top
   import desa_pkg::*;
#(
   parameter int ARENA_BYTES  = 1024,
   parameter int HEADER_BYTES = 20,
   parameter int PTR_BYTES    = 4,
   parameter int MARK_DEPTH   = 64
) (
   input wire logic   clock,
   input wire logic   reset,
   desa_req_if.sink   req_if,
   desa_rsp_if.source rsp_if
);

   localparam logic [ADDR_W-1:0] LOW_RESET  = ADDR_W'(HEADER_BYTES + PTR_BYTES);
   localparam logic [ADDR_W-1:0] HIGH_RESET = ADDR_W'(ARENA_BYTES - PTR_BYTES);
   localparam logic [ADDR_W-1:0] LOW_BASE   = ADDR_W'(HEADER_BYTES);
   localparam logic [ADDR_W-1:0] HIGH_BASE  = ADDR_W'(ARENA_BYTES);
   localparam logic [ADDR_W-1:0] PTR_SIZE   = ADDR_W'(PTR_BYTES);

   // input register
   logic              s1_valid_ff;
   op_type            s1_op_ff;
   logic              s1_dir_ff;
   logic [ADDR_W-1:0] s1_bytes_ff;

   // result register
   logic              out_valid_ff;
   logic [ADDR_W-1:0] out_addr_ff, out_addr_in;
   status_type        out_status_ff, out_status_in;
   logic [ADDR_W-1:0] out_free_ff, out_free_in;

   // allocator tops
   logic [ADDR_W-1:0] low_top_ff, low_top_in;
   logic [ADDR_W-1:0] high_top_ff, high_top_in;

   stk_cmd_type  low_cmd, high_cmd;
   stk_stat_type low_stat, high_stat;
   stk_stat_type side_stat;

   logic            adv, exec;
   logic [ADDR_W:0] need_sum;
   logic [ADDR_W-1:0] need_bytes;
   logic            fits;
   logic [ADDR_W-1:0] side_top;
   logic            do_push, do_pop;

   assign adv  = !out_valid_ff || rsp_if.ready;
   assign exec = s1_valid_ff && adv;
   assign req_if.ready = !s1_valid_ff || adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         s1_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.ready) begin
         s1_op_ff    <= op_type'(req_if.req_type);
         s1_dir_ff   <= req_if.direction;
         s1_bytes_ff <= req_if.alloc_bytes;
      end
   end

   assign side_stat  = s1_dir_ff ? high_stat : low_stat;
   assign side_top   = s1_dir_ff ? high_top_ff : low_top_ff;
   assign need_bytes = (s1_op_ff == OP_ALLOC) ? s1_bytes_ff : PTR_SIZE;
   assign need_sum   = {1'b0, low_top_ff} + {1'b0, need_bytes};
   assign fits       = (need_sum <= {1'b0, high_top_ff});

   always_comb begin
      low_top_in    = low_top_ff;
      high_top_in   = high_top_ff;
      out_addr_in   = '0;
      out_status_in = ST_OK;
      do_push       = 1'b0;
      do_pop        = 1'b0;
      case (s1_op_ff)
         OP_ALLOC: begin
            if (!fits) begin
               out_status_in = ST_OOM;
            end else if (s1_dir_ff) begin
               high_top_in = high_top_ff - s1_bytes_ff;
               out_addr_in = high_top_in;
            end else begin
               low_top_in  = need_sum[ADDR_W-1:0];
               out_addr_in = low_top_ff;
            end
         end
         OP_MARK: begin
            // full is checked before memory
            if (side_stat.full) begin
               out_status_in = ST_FULL;
            end else if (!fits) begin
               out_status_in = ST_OOM;
            end else begin
               do_push     = 1'b1;
               out_addr_in = side_top;
               if (s1_dir_ff) begin
                  high_top_in = high_top_ff - PTR_SIZE;
               end else begin
                  low_top_in = need_sum[ADDR_W-1:0];
               end
            end
         end
         OP_REWIND: begin
            if (side_stat.base_only) begin
               out_status_in = ST_REWIND;
            end else begin
               do_pop      = 1'b1;
               out_addr_in = side_stat.top_mark;
               if (s1_dir_ff) begin
                  high_top_in = side_stat.top_mark;
               end else begin
                  low_top_in = side_stat.top_mark;
               end
            end
         end
         default: begin
            if (side_stat.base_only) begin
               out_status_in = ST_DROP;
            end else begin
               do_pop      = 1'b1;
               out_addr_in = s1_dir_ff ? (side_stat.top_mark - PTR_SIZE)
                                       : side_stat.top_mark;
            end
         end
      endcase
      out_free_in = (high_top_in >= low_top_in) ? (high_top_in - low_top_in) : '0;
   end

   assign low_cmd.push  = exec && do_push && !s1_dir_ff;
   assign low_cmd.pop   = exec && do_pop && !s1_dir_ff;
   assign low_cmd.data  = low_top_ff;
   assign high_cmd.push = exec && do_push && s1_dir_ff;
   assign high_cmd.pop  = exec && do_pop && s1_dir_ff;
   assign high_cmd.data = high_top_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_top_ff   <= LOW_RESET;
         high_top_ff  <= HIGH_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         if (exec) begin
            low_top_ff  <= low_top_in;
            high_top_ff <= high_top_in;
         end
         if (adv) begin
            out_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         out_addr_ff   <= out_addr_in;
         out_status_ff <= out_status_in;
         out_free_ff   <= out_free_in;
      end
   end

   desa_mark_stack #(
      .MARK_DEPTH (MARK_DEPTH),
      .BASE_MARK  (LOW_BASE)
   ) u_low_stack (
      .clock (clock),
      .reset (reset),
      .cmd   (low_cmd),
      .stat  (low_stat)
   );

   desa_mark_stack #(
      .MARK_DEPTH (MARK_DEPTH),
      .BASE_MARK  (HIGH_BASE)
   ) u_high_stack (
      .clock (clock),
      .reset (reset),
      .cmd   (high_cmd),
      .stat  (high_stat)
   );

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.address    = out_addr_ff;
   assign rsp_if.status     = out_status_ff;
   assign rsp_if.free_bytes = out_free_ff;

endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
// Testbench: random and directed requests against a predictor of the double-ended stack allocator.
`timescale 1ns / 1ps
module testbench;
   import desa_pkg::*;

   localparam int ARENA      = 1024;
   localparam int HEADER     = 20;
   localparam int PTR        = 4;
   localparam int DEPTH      = 64;
   localparam int ITEMS      = 1700;
   localparam int IDLE_LIMIT = 4000;
   localparam int MAX_REPORTS = 10;

   // Predicts each response from its own copy of both tops and both mark stacks.
   class alloc_scoreboard;
      typedef struct {
         logic [15:0] address;
         status_type  status;
         logic [15:0] free_bytes;
      } alloc_result;

      alloc_result results_due[$];
      int unsigned tops[2];
      int unsigned marks[2][DEPTH];
      int unsigned counts[2];
      int unsigned failures;

      function new();
         foreach (marks[i, j]) marks[i][j] = 0;
         tops[0] = HEADER + PTR;
         tops[1] = ARENA - PTR;
         marks[0][0] = HEADER;
         marks[1][0] = ARENA;
         counts[0] = 1;
         counts[1] = 1;
         failures = 0;
      endfunction

      // Saturates at zero if the tops ever cross.
      function int unsigned room();
         return (tops[1] >= tops[0]) ? tops[1] - tops[0] : 0;
      endfunction

      function int unsigned depth(bit side);
         return counts[side];
      endfunction

      function int unsigned pending();
         return results_due.size();
      endfunction

      function void note(op_type op, bit side, logic [15:0] bytes);
         alloc_result r;
         r.address = '0;
         r.status  = ST_OK;
         case (op)
            OP_ALLOC: begin
               if (tops[0] + bytes > tops[1]) begin
                  r.status = ST_OOM;
               end else if (side) begin
                  tops[1] -= bytes;
                  r.address = 16'(tops[1]);
               end else begin
                  r.address = 16'(tops[0]);
                  tops[0] += bytes;
               end
            end
            OP_MARK: begin
               // full stack wins over out of memory
               if (counts[side] >= DEPTH) begin
                  r.status = ST_FULL;
               end else if (tops[0] + PTR > tops[1]) begin
                  r.status = ST_OOM;
               end else begin
                  marks[side][counts[side]] = tops[side];
                  counts[side]++;
                  r.address = 16'(tops[side]);
                  if (side) tops[1] -= PTR;
                  else tops[0] += PTR;
               end
            end
            OP_REWIND: begin
               if (counts[side] <= 1) begin
                  r.status = ST_REWIND;
               end else begin
                  counts[side]--;
                  tops[side] = marks[side][counts[side]];
                  r.address = 16'(tops[side]);
               end
            end
            default: begin
               if (counts[side] <= 1) begin
                  r.status = ST_DROP;
               end else begin
                  counts[side]--;
                  r.address = 16'(side ? marks[side][counts[side]] - PTR
                                       : marks[side][counts[side]]);
               end
            end
         endcase
         r.free_bytes = 16'(room());
         results_due.push_back(r);
      endfunction

      function void check(logic [15:0] address, logic [2:0] status, logic [15:0] free_bytes);
         alloc_result e;
         if (results_due.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("%0t: response with none pending: addr %0d status %0d free %0d",
                        $time, address, status, free_bytes);
         end else begin
            e = results_due.pop_front();
            if (address !== e.address || status !== e.status || free_bytes !== e.free_bytes) begin
               failures++;
               if (failures <= MAX_REPORTS)
                  $display("%0t: mismatch: expected addr %0d status %0d free %0d, got addr %0d status %0d free %0d",
                           $time, e.address, e.status, e.free_bytes,
                           address, status, free_bytes);
            end
         end
      endfunction

      function bit clean();
         return failures == 0 && results_due.size() == 0;
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   steady;
   int unsigned items_sent;
   int unsigned idle_cycles;

   desa_req_if req_ch ();
   desa_rsp_if rsp_ch ();

   alloc_scoreboard sb = new();

   double_ended_stack_allocator_top #(
      .ARENA_BYTES (ARENA),
      .HEADER_BYTES(HEADER),
      .PTR_BYTES   (PTR),
      .MARK_DEPTH  (DEPTH)
   ) DUT (
      .clock (clock),
      .reset (reset),
      .req_if(req_ch),
      .rsp_if(rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly short gaps, a few long; none during steady stretches
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (steady) return 0;
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   initial begin
      steady <= 1'b0;
      forever begin
         repeat ($urandom_range(300, 800)) @(posedge clock);
         steady <= 1'b1;
         repeat ($urandom_range(50, 150)) @(posedge clock);
         steady <= 1'b0;
      end
   end

   // response side back-pressure
   initial begin
      int unsigned gap;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 30)) @(posedge clock);
         gap = pick_gap();
         if (gap != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check(rsp_ch.address, rsp_ch.status, rsp_ch.free_bytes);
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
         $display("double_ended_stack_allocator_top regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic issue(op_type op, bit side, logic [15:0] bytes);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.req_type    <= op;
      req_ch.direction   <= side;
      req_ch.alloc_bytes <= bytes;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note(op, side, bytes);
      items_sent++;
   endtask

   // hold off new requests until every response is back
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic run_directed();
      issue(OP_ALLOC, 1'b0, 16'd0);
      issue(OP_ALLOC, 1'b0, 16'hFFFF);
      issue(OP_ALLOC, 1'b1, 16'hFFFF);
      issue(OP_REWIND, 1'b0, 16'd0);        // base mark only
      issue(OP_DROPMARK, 1'b1, 16'd0);
      issue(OP_REWIND, 1'b1, 16'hFFFF);
      issue(OP_DROPMARK, 1'b0, 16'hFFFF);
      issue(OP_MARK, 1'b0, 16'd0);
      issue(OP_MARK, 1'b1, 16'd0);
      issue(OP_MARK, 1'b1, 16'd0);
      issue(OP_DROPMARK, 1'b1, 16'd0);
      issue(OP_ALLOC, 1'b0, 16'd100);
      issue(OP_ALLOC, 1'b1, 16'd200);
      issue(OP_MARK, 1'b0, 16'd0);
      issue(OP_ALLOC, 1'b1, 16'(sb.room())); // exact fit leaves nothing
      issue(OP_MARK, 1'b1, 16'd0);           // no room for the mark slot
      issue(OP_ALLOC, 1'b0, 16'd1);
      issue(OP_ALLOC, 1'b0, 16'd0);
      issue(OP_DROPMARK, 1'b0, 16'd0);
      issue(OP_REWIND, 1'b1, 16'd0);
      issue(OP_ALLOC, 1'b0, 16'(sb.room()));
      issue(OP_REWIND, 1'b0, 16'd0);
      issue(OP_DROPMARK, 1'b1, 16'd0);
      issue(OP_ALLOC, 1'b1, 16'hAAAA);
      issue(OP_ALLOC, 1'b0, 16'h5555);
   endtask

   // Mostly nested mark/alloc/rewind sequences; base-level allocs kept tiny so
   // the arena does not leak away for good.
   task automatic choose(output op_type op, output bit side, output logic [15:0] bytes);
      int unsigned r;
      int unsigned room;
      int unsigned d;
      int unsigned cap;
      side  = $urandom_range(0, 1);
      r     = $urandom_range(0, 99);
      room  = sb.room();
      d     = sb.depth(side);
      bytes = 16'($urandom);
      if (r < 6) begin
         op = op_type'($urandom_range(0, 3));
      end else if (d == 1 && r < 80) begin
         op = OP_MARK;
      end else if (room < 48 && d > 1 && r < 70) begin
         op = OP_REWIND;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 45) begin
            op = OP_ALLOC;
            cap = (room < 64) ? room : 64;
            if (d == 1) bytes = 16'($urandom_range(0, 3));
            else if ($urandom_range(0, 9) == 0) bytes = 16'(room);
            else bytes = 16'($urandom_range(0, cap));
         end else if (r < 70) begin
            op = OP_MARK;
         end else if (r < 88) begin
            op = OP_REWIND;
         end else begin
            op = (d == 2 && $urandom_range(0, 9) != 0) ? OP_REWIND : OP_DROPMARK;
         end
      end
   endtask

   initial begin
      op_type      op;
      bit          side;
      logic [15:0] bytes;
      int unsigned n;
      bit          drained_once;
      drained_once = 1'b0;
      items_sent   = 0;
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.req_type    <= OP_ALLOC;
      req_ch.direction   <= 1'b0;
      req_ch.alloc_bytes <= 16'd0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      while (items_sent < ITEMS) begin
         if ((!drained_once && items_sent >= ITEMS / 2) || $urandom_range(0, 299) == 0) begin
            drain();
            drained_once = 1'b1;
         end
         side = $urandom_range(0, 1);
         if (sb.room() > 300 && sb.depth(side) < 4 && $urandom_range(0, 119) == 0) begin
            // fill the mark stack past full, then unwind past the base mark
            n = DEPTH - sb.depth(side) + $urandom_range(0, 3);
            repeat (n) issue(OP_MARK, side, 16'($urandom));
            repeat (n + $urandom_range(1, 2)) begin
               if (sb.depth(side) == 2 || $urandom_range(0, 5) != 0) op = OP_REWIND;
               else op = OP_DROPMARK;
               issue(op, side, 16'($urandom));
            end
         end else begin
            choose(op, side, bytes);
            issue(op, side, bytes);
         end
      end

      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      if (sb.clean())
         $display("double_ended_stack_allocator_top regression: pass");
      else
         $display("double_ended_stack_allocator_top regression: fail");
      $finish;
   end

endmodule
